[src/dda_pkg.sv]
// Shared types and constants for the fixed-point line rasterizer.
// Used by dda_divider and dda_line_rasterizer; depends on nothing else.
package dda_pkg;

   // Fixed-point format of the accumulators and increments.
   localparam int FracBits = 16;
   localparam int AccW     = 32;
   localparam int IntW     = AccW - FracBits;

   // Coordinate, delta and magnitude widths.
   localparam int CoordW   = 15;
   localparam int DeltaW   = CoordW + 1;
   localparam int MagW     = CoordW;
   localparam int CountW   = 16;

   // Divider widths: the quotient never exceeds one whole unit.
   localparam int RemW     = MagW + 1;
   localparam int QuotW    = FracBits + 1;
   localparam int IterW    = $clog2(QuotW + 1);

   // Screen size registers.
   localparam int ScreenW  = 13;
   localparam logic [ScreenW-1:0] ScreenWidthReset  = ScreenW'(640);
   localparam logic [ScreenW-1:0] ScreenHeightReset = ScreenW'(480);

   // Configuration register indexes.
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] REG_SCREEN_WIDTH  = 1'b0;
   localparam logic [CsrIdxW-1:0] REG_SCREEN_HEIGHT = 1'b1;

   // Command codes carried on the request tuser.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_DIV_X = 4'b0100,
      ST_DIV_Y = 4'b1000
   } state_type;

   // Request into the shared divider.
   typedef struct packed {
      logic            start;
      logic [MagW-1:0] dividend;
      logic [MagW-1:0] divisor;
   } div_req_type;

   // Result from the shared divider.
   typedef struct packed {
      logic             done;
      logic [QuotW-1:0] quotient;
   } div_rsp_type;

endpackage

[src/dda_divider.sv]
// Restoring divider that forms (dividend << FracBits) / divisor, one quotient bit per cycle.
// Depends on dda_pkg; the dividend must not exceed the divisor.
module dda_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  dda_pkg::div_req_type req,
   output dda_pkg::div_rsp_type rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [dda_pkg::IterW-1:0]    iter_ff, iter_in;
   logic [dda_pkg::RemW-1:0]     rem_ff, rem_in;
   logic [dda_pkg::MagW-1:0]     div_ff, div_in;
   logic [dda_pkg::QuotW-1:0]    quot_ff, quot_in;
   logic [dda_pkg::RemW:0]       trial;
   logic                         qbit;
   logic [dda_pkg::RemW-1:0]     rem_kept;

   // Trial subtraction of the divisor from the partial remainder.
   always_comb begin
      trial    = {1'b0, rem_ff} - {2'b00, div_ff};
      qbit     = !trial[dda_pkg::RemW];
      rem_kept = qbit ? trial[dda_pkg::RemW-1:0] : rem_ff;
   end

   // Sequencing of the iterations.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         iter_in = dda_pkg::IterW'(dda_pkg::QuotW);
         rem_in  = {1'b0, req.dividend};
         div_in  = req.divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         // The kept remainder is below the divisor, so doubling it cannot overflow.
         rem_in  = {rem_kept[dda_pkg::RemW-2:0], 1'b0};
         quot_in = {quot_ff[dda_pkg::QuotW-2:0], qbit};
         iter_in = iter_ff - 1'b1;
         if (iter_ff == dda_pkg::IterW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

[src/dda_line_rasterizer.sv]
// Top level of the DDA line rasterizer in 16.16 fixed point.
// Depends on dda_pkg and dda_divider.
//
// Usage:
//   The request channel carries commands. tuser is the command: start a line from the
//   two endpoints in tdata, or step to the next pixel. A start emits nothing and drops
//   any line in progress. Each step of an active line emits one pixel on the response
//   channel; tlast marks the final pixel and tuser flags a pixel inside the screen.
//   A step while no line is active is taken and emits nothing.
//   Throughput: a step's pixel appears in the response register on the next cycle, so
//   steps run at one per cycle while the receiver takes each pixel. A start keeps
//   req_tready low through the SETUP, DIV_X and DIV_Y states while the single shared
//   restoring divider forms the x and then the y increment, one quotient bit per cycle.
//   When the receiver stalls, the pixel waits in the response register and the block
//   takes no command until it is taken (or is taken in the same cycle).
//   Reset (synchronous) leaves no line active, the response channel empty and the
//   screen size at 640 by 480. Screen size is to be written on the csr port only while
//   idle; the block itself does not enforce it.
module dda_line_rasterizer (
   input  logic                          clock,
   input  logic                          reset,
   // Command transaction.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata from bit 0: x_start[14:0], y_start[14:0], x_end[14:0], y_end[14:0], zero fill.
   input  logic [63:0]                   req_tdata,
   // tuser: command (0 = start, 1 = step).
   input  logic                          req_tuser,
   // Pixel transaction.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata from bit 0: pixel_x[14:0], pixel_y[14:0], zero fill.
   output logic [31:0]                   rsp_tdata,
   // tuser: on_screen.
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   // Configuration writes.
   input  logic                          csr_we,
   input  logic [dda_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [dda_pkg::ScreenW-1:0]   csr_wdata
);

   localparam int CW = dda_pkg::CoordW;
   localparam int SignPad = dda_pkg::AccW - CW - dda_pkg::FracBits;

   dda_pkg::state_type               state_ff, state_in;
   logic [dda_pkg::ScreenW-1:0]      width_ff, width_in;
   logic [dda_pkg::ScreenW-1:0]      height_ff, height_in;
   logic [dda_pkg::AccW-1:0]         accum_x_ff, accum_x_in;
   logic [dda_pkg::AccW-1:0]         accum_y_ff, accum_y_in;
   logic [dda_pkg::AccW-1:0]         step_x_ff, step_x_in;
   logic [dda_pkg::AccW-1:0]         step_y_ff, step_y_in;
   logic [dda_pkg::CountW-1:0]       left_ff, left_in;
   logic                             active_ff, active_in;
   logic [dda_pkg::MagW-1:0]         mag_x_ff, mag_x_in;
   logic [dda_pkg::MagW-1:0]         mag_y_ff, mag_y_in;
   logic                             neg_x_ff, neg_x_in;
   logic                             neg_y_ff, neg_y_in;
   logic [dda_pkg::MagW-1:0]         steps_ff, steps_in;
   logic                             out_valid_ff, out_valid_in;
   logic [2*CW-1:0]                  out_xy_ff, out_xy_in;
   logic                             out_vis_ff, out_vis_in;
   logic                             out_last_ff, out_last_in;

   logic                             accept;
   logic signed [CW-1:0]             x1, y1, x2, y2;
   logic [dda_pkg::DeltaW-1:0]       dx, dy, abs_x, abs_y;
   logic [dda_pkg::MagW-1:0]         new_steps;
   logic [dda_pkg::IntW-1:0]         ix, iy;
   logic                             fin;
   logic [dda_pkg::AccW-1:0]         quot_ext, quot_signed;
   logic                             quot_neg;
   dda_pkg::div_req_type             div_req;
   dda_pkg::div_rsp_type             div_rsp;

   dda_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Commands are taken only while idle and with room in the response register.
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == dda_pkg::ST_IDLE) && (!out_valid_ff || rsp_tready);

   // Endpoint deltas and the step count of a new line.
   always_comb begin
      x1        = req_tdata[CW-1:0];
      y1        = req_tdata[2*CW-1:CW];
      x2        = req_tdata[3*CW-1:2*CW];
      y2        = req_tdata[4*CW-1:3*CW];
      dx        = {x2[CW-1], x2} - {x1[CW-1], x1};
      dy        = {y2[CW-1], y2} - {y1[CW-1], y1};
      abs_x     = dx[dda_pkg::DeltaW-1] ? -dx : dx;
      abs_y     = dy[dda_pkg::DeltaW-1] ? -dy : dy;
      new_steps = (abs_x > abs_y) ? abs_x[dda_pkg::MagW-1:0] : abs_y[dda_pkg::MagW-1:0];
   end

   // Integer part of the accumulators and the last-pixel test.
   always_comb begin
      ix  = accum_x_ff[dda_pkg::AccW-1:dda_pkg::FracBits];
      iy  = accum_y_ff[dda_pkg::AccW-1:dda_pkg::FracBits];
      fin = (left_ff <= dda_pkg::CountW'(1));
   end

   // Signed increment from the unsigned quotient; a zero-length line steps by zero.
   always_comb begin
      quot_neg    = (state_ff == dda_pkg::ST_DIV_X) ? neg_x_ff : neg_y_ff;
      quot_ext    = {{(dda_pkg::AccW - dda_pkg::QuotW){1'b0}}, div_rsp.quotient};
      quot_signed = quot_neg ? (~quot_ext + 1'b1) : quot_ext;
      if (steps_ff == '0) begin
         quot_signed = '0;
      end
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      accum_x_in   = accum_x_ff;
      accum_y_in   = accum_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      left_in      = left_ff;
      active_in    = active_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      steps_in     = steps_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_xy_in    = out_xy_ff;
      out_vis_in   = out_vis_ff;
      out_last_in  = out_last_ff;
      div_req.start    = 1'b0;
      div_req.dividend = mag_x_ff;
      div_req.divisor  = steps_ff;

      if (csr_we) begin
         case (csr_index)
            dda_pkg::REG_SCREEN_WIDTH:  width_in  = csr_wdata;
            dda_pkg::REG_SCREEN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         dda_pkg::ST_IDLE: begin
            if (accept && req_tuser == dda_pkg::CMD_START) begin
               accum_x_in = {{SignPad{x1[CW-1]}}, x1, {dda_pkg::FracBits{1'b0}}};
               accum_y_in = {{SignPad{y1[CW-1]}}, y1, {dda_pkg::FracBits{1'b0}}};
               mag_x_in   = abs_x[dda_pkg::MagW-1:0];
               mag_y_in   = abs_y[dda_pkg::MagW-1:0];
               neg_x_in   = dx[dda_pkg::DeltaW-1];
               neg_y_in   = dy[dda_pkg::DeltaW-1];
               steps_in   = new_steps;
               left_in    = {1'b0, new_steps} + 1'b1;
               active_in  = 1'b1;
               state_in   = dda_pkg::ST_SETUP;
            end else if (accept && active_ff) begin
               // Emit the current pixel, then advance along the line.
               out_valid_in = 1'b1;
               out_xy_in    = {iy[CW-1:0], ix[CW-1:0]};
               out_vis_in   = !ix[dda_pkg::IntW-1] && !iy[dda_pkg::IntW-1] &&
                  (ix < {{(dda_pkg::IntW - dda_pkg::ScreenW){1'b0}}, width_ff}) &&
                  (iy < {{(dda_pkg::IntW - dda_pkg::ScreenW){1'b0}}, height_ff});
               out_last_in  = fin;
               accum_x_in   = accum_x_ff + step_x_ff;
               accum_y_in   = accum_y_ff + step_y_ff;
               if (fin) begin
                  left_in   = '0;
                  active_in = 1'b0;
               end else begin
                  left_in   = left_ff - 1'b1;
               end
            end
         end
         dda_pkg::ST_SETUP: begin
            // Launch the x increment division.
            div_req.start = 1'b1;
            state_in      = dda_pkg::ST_DIV_X;
         end
         dda_pkg::ST_DIV_X: begin
            if (div_rsp.done) begin
               step_x_in        = quot_signed;
               div_req.start    = 1'b1;
               div_req.dividend = mag_y_ff;
               state_in         = dda_pkg::ST_DIV_Y;
            end
         end
         dda_pkg::ST_DIV_Y: begin
            if (div_rsp.done) begin
               step_y_in = quot_signed;
               state_in  = dda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dda_pkg::ST_IDLE;
         end
      endcase
   end

   // Registers: control and screen size are reset, the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dda_pkg::ST_IDLE;
         width_ff     <= dda_pkg::ScreenWidthReset;
         height_ff    <= dda_pkg::ScreenHeightReset;
         left_ff      <= '0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         left_ff      <= left_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      accum_x_ff  <= accum_x_in;
      accum_y_ff  <= accum_y_in;
      step_x_ff   <= step_x_in;
      step_y_ff   <= step_y_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      steps_ff    <= steps_in;
      out_xy_ff   <= out_xy_in;
      out_vis_ff  <= out_vis_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(32 - 2*CW){1'b0}}, out_xy_ff};
   assign rsp_tuser  = out_vis_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[test/dda_line_rasterizer_tb.sv]
// Self-checking testbench for the DDA line rasterizer in 16.16 fixed point.
// Depends on dda_pkg and on the RTL of dda_line_rasterizer; reads no files.
module dda_line_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FracBits     = dda_pkg::FracBits;
   localparam int AccW         = dda_pkg::AccW;
   localparam int CoordW       = dda_pkg::CoordW;
   localparam int CountW       = dda_pkg::CountW;
   localparam int ScreenW      = dda_pkg::ScreenW;
   localparam int CsrIdxW      = dda_pkg::CsrIdxW;

   localparam int ClockPeriod  = 10;
   localparam int ResetCycles  = 8;
   localparam int CycleLimit   = 600000;
   localparam int MaxReports   = 10;
   localparam int PhaseItems   = 85;
   localparam int NumPhases    = 6;
   // A start holds the command side for the two divisions; give it some margin.
   localparam int SettleCycles = 2 * (FracBits + 1) + 3 + 8;

   // One emitted pixel as it travels on the response channel.
   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic                     on_screen;
      logic                     last;
   } pixel_type;

   // One directed command; typed rows carry their expected outcome by hand.
   typedef struct packed {
      logic                     cmd;
      logic signed [CoordW-1:0] x1;
      logic signed [CoordW-1:0] y1;
      logic signed [CoordW-1:0] x2;
      logic signed [CoordW-1:0] y2;
      logic                     typed;
      logic                     emits;
      pixel_type                pix;
   } directed_row_type;

   localparam pixel_type NoPix = '0;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [63:0]         req_tdata  = '0;
   logic                req_tuser  = dda_pkg::CMD_STEP;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [31:0]         rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we     = 1'b0;
   logic [CsrIdxW-1:0]  csr_index  = dda_pkg::REG_SCREEN_WIDTH;
   logic [ScreenW-1:0]  csr_wdata  = '0;

   // Shadow state of the rasterizer.
   logic [ScreenW-1:0]  width_reg  = dda_pkg::ScreenWidthReset;
   logic [ScreenW-1:0]  height_reg = dda_pkg::ScreenHeightReset;
   logic [AccW-1:0]     acc_x      = '0;
   logic [AccW-1:0]     acc_y      = '0;
   logic [AccW-1:0]     inc_x      = '0;
   logic [AccW-1:0]     inc_y      = '0;
   logic [CountW-1:0]   pixels_left = '0;
   bit                  drawing    = 1'b0;

   pixel_type pending_pixels [$];
   pixel_type got_pixel;
   pixel_type want_pixel;
   int     mismatch_count = 0;
   int     counted_items  = 0;
   int     cycle_count    = 0;
   int     stall_left     = 0;
   bit     idle_on        = 1'b1;

   directed_row_type directed_rows [25] = '{
      // Step while no line is active: taken, nothing emitted.
      '{dda_pkg::CMD_STEP,  16383, -16384, 16383, -16384, 1'b1, 1'b0, NoPix},
      // Zero-length line emits its single point, marked last.
      '{dda_pkg::CMD_START, 0, 0, 0, 0, 1'b1, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, 1'b1, '{0, 0, 1'b1, 1'b1}},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, 1'b0, NoPix},
      // Full-range diagonal, then abandoned by the reverse diagonal.
      '{dda_pkg::CMD_START, -16384, -16384, 16383, 16383, 1'b1, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, 1'b1, '{-16384, -16384, 1'b0, 1'b0}},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, 1'b0, NoPix},
      '{dda_pkg::CMD_START, 16383, 16383, -16384, -16384, 1'b1, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, 1'b1, '{16383, 16383, 1'b0, 1'b0}},
      // One step across the right edge of the reset screen size.
      '{dda_pkg::CMD_START, 639, 479, 640, 478, 1'b1, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, 1'b1, '{639, 479, 1'b1, 1'b0}},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, 1'b1, '{640, 478, 1'b0, 1'b1}},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, 1'b0, NoPix},
      // Steep line with a negative x increment that truncates toward zero.
      '{dda_pkg::CMD_START, 0, 0, -3, 7, 1'b1, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, 1'b1, '{0, 0, 1'b1, 1'b0}},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, 1'b0, NoPix},
      // Line starting at a negative y, off screen at its first pixel.
      '{dda_pkg::CMD_START, 3, -1, -5, 2, 1'b1, 1'b0, NoPix},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b1, 1'b1, '{3, -1, 1'b0, 1'b0}},
      '{dda_pkg::CMD_STEP,  0, 0, 0, 0, 1'b0, 1'b0, NoPix}
   };

   dda_line_rasterizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Mostly back to back, sometimes a short gap, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(0, 32767)) - 16384;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < -16384) return -16384;
      if (v > 16383) return 16383;
      return v;
   endfunction

   // Advance the shadow rasterizer by one command and return the pixel it emits.
   task automatic rasterize_command(input logic cmd,
                                    input logic signed [CoordW-1:0] x1, y1, x2, y2,
                                    output bit emits, output pixel_type pix);
      longint dx, dy, ax, ay, span, scale, ix, iy;
      scale = longint'(1) << FracBits;
      emits = 1'b0;
      pix   = NoPix;
      if (cmd == dda_pkg::CMD_START) begin
         dx = longint'(x2) - longint'(x1);
         dy = longint'(y2) - longint'(y1);
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         span = (ax > ay) ? ax : ay;
         acc_x = AccW'(longint'(x1) * scale);
         acc_y = AccW'(longint'(y1) * scale);
         // Signed division truncates toward zero, as the increments require.
         inc_x = (span == 0) ? '0 : AccW'((dx * scale) / span);
         inc_y = (span == 0) ? '0 : AccW'((dy * scale) / span);
         pixels_left = CountW'(span + 1);
         drawing = 1'b1;
      end else if (drawing) begin
         ix = longint'($signed(acc_x) >>> FracBits);
         iy = longint'($signed(acc_y) >>> FracBits);
         emits = 1'b1;
         pix.x = CoordW'(ix);
         pix.y = CoordW'(iy);
         pix.on_screen = (ix >= 0) && (ix < longint'(width_reg)) &&
                         (iy >= 0) && (iy < longint'(height_reg));
         pix.last = (pixels_left <= 1);
         acc_x = acc_x + inc_x;
         acc_y = acc_y + inc_y;
         if (pix.last) begin
            pixels_left = '0;
            drawing = 1'b0;
         end else begin
            pixels_left = pixels_left - 1'b1;
         end
      end
   endtask

   // Present one command transaction and record the pixel it should produce.
   task automatic drive_command(input logic cmd, input int x1, y1, x2, y2,
                                input bit typed, input bit typed_emits,
                                input pixel_type typed_pix);
      int        gap;
      bit        emits;
      pixel_type pix;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, CoordW'(y2), CoordW'(x2), CoordW'(y1), CoordW'(x1)};
      do @(posedge clock); while (!req_tready);
      rasterize_command(cmd, CoordW'(x1), CoordW'(y1), CoordW'(x2), CoordW'(y2),
                        emits, pix);
      if (typed) begin
         emits = typed_emits;
         pix   = typed_pix;
      end
      if (emits) pending_pixels.insert(pending_pixels.size(), pix);
      if (cmd == dda_pkg::CMD_START || emits) counted_items++;
   endtask

   // Drain the pipeline so that the screen size can be changed safely.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] index, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= ScreenW'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      if (index == dda_pkg::REG_SCREEN_WIDTH) width_reg = ScreenW'(value);
      else height_reg = ScreenW'(value);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MaxReports)
            $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Receiver: random stalls on the pixel channel.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // Compare every accepted pixel transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_pixel.x         = rsp_tdata[CoordW-1:0];
         got_pixel.y         = rsp_tdata[2*CoordW-1:CoordW];
         got_pixel.on_screen = rsp_tuser;
         got_pixel.last      = rsp_tlast;
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports)
               $display("unexpected pixel (%0d, %0d) with nothing pending",
                        got_pixel.x, got_pixel.y);
         end else begin
            want_pixel = pending_pixels.pop_front();
            check_field("pixel_x", want_pixel.x, got_pixel.x);
            check_field("pixel_y", want_pixel.y, got_pixel.y);
            check_field("on_screen", want_pixel.on_screen, got_pixel.on_screen);
            check_field("last", want_pixel.last, got_pixel.last);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int phase, r, x1, y1, x2, y2, dx, dy, span, n, target, xb, yb;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed commands at the reset screen size.
      foreach (directed_rows[i])
         drive_command(directed_rows[i].cmd, directed_rows[i].x1, directed_rows[i].y1,
                       directed_rows[i].x2, directed_rows[i].y2, directed_rows[i].typed,
                       directed_rows[i].emits, directed_rows[i].pix);
      settle();

      // Random traffic over several screen sizes, extremes first.
      for (phase = 0; phase < NumPhases; phase++) begin
         case (phase)
            0: begin xb = 1;    yb = 1;    end
            1: begin xb = 4096; yb = 4096; end
            2: begin xb = 0;    yb = 8191; end
            3: begin xb = 8191; yb = 0;    end
            default: begin
               xb = $urandom_range(1, 4096);
               yb = $urandom_range(1, 4096);
            end
         endcase
         write_csr(dda_pkg::REG_SCREEN_WIDTH, xb);
         write_csr(dda_pkg::REG_SCREEN_HEIGHT, yb);
         idle_on = (phase != 2);
         target = counted_items + PhaseItems;
         while (counted_items < target) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
               // A whole line, mostly short and near the screen edges.
               if ($urandom_range(0, 99) < 60) begin
                  xb = $urandom_range(0, 1) ? int'(width_reg) : 0;
                  yb = $urandom_range(0, 1) ? int'(height_reg) : 0;
                  x1 = clamp_coord(xb + int'($urandom_range(0, 40)) - 20);
                  y1 = clamp_coord(yb + int'($urandom_range(0, 40)) - 20);
               end else begin
                  x1 = rand_coord();
                  y1 = rand_coord();
               end
               if ($urandom_range(0, 99) < 85) begin
                  x2 = clamp_coord(x1 + int'($urandom_range(0, 24)) - 12);
                  y2 = clamp_coord(y1 + int'($urandom_range(0, 24)) - 12);
               end else begin
                  x2 = rand_coord();
                  y2 = rand_coord();
               end
               drive_command(dda_pkg::CMD_START, x1, y1, x2, y2, 1'b0, 1'b0, NoPix);
               dx = (x2 > x1) ? x2 - x1 : x1 - x2;
               dy = (y2 > y1) ? y2 - y1 : y1 - y2;
               span = (dx > dy) ? dx : dy;
               if (span <= 40)
                  n = span + 1 + (($urandom_range(0, 99) < 30) ? $urandom_range(1, 2) : 0);
               else
                  n = $urandom_range(1, 30);
               // Now and then the line is cut short by the next start.
               if ($urandom_range(0, 99) < 10) n = $urandom_range(0, n);
               repeat (n)
                  drive_command(dda_pkg::CMD_STEP, rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), 1'b0, 1'b0, NoPix);
            end else if (r < 90) begin
               drive_command(dda_pkg::CMD_STEP, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), 1'b0, 1'b0, NoPix);
            end else begin
               drive_command(dda_pkg::CMD_START, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), 1'b0, 1'b0, NoPix);
            end
         end
         settle();
      end

      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
src/dda_pkg.sv
src/dda_divider.sv
src/dda_line_rasterizer.sv
test/dda_line_rasterizer_tb.sv
